// ===== sv/lzsd_pkg.sv =====
// Shared types and constants for the LZSS stream decompressor.
package lzsd_pkg;

    // Default size of the history ring in bytes.
    localparam int unsigned HISTORY_DEPTH_DEF = 4096;
    // Default width of the output byte counter.
    localparam int unsigned LENGTH_WIDTH_DEF = 24;

    // Fixed payload widths.
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned TOTAL_W = 24;
    localparam int unsigned LEFT_W  = 5;

    // Number of flags carried by one tag byte.
    localparam logic [3:0] FLAGS_PER_TAG = 4'd8;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PARSE,
        ST_READ,
        ST_COPY
    } state_t;

    // What the next compressed byte is expected to be.
    typedef enum logic [1:0] {
        PH_TAG,
        PH_ITEM,
        PH_LOW
    } phase_t;

endpackage

// ===== sv/lzsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lzsd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/lzss_stream_decompressor_core.sv =====
// Top level of the LZSS stream decompressor with a 4 KiB history ring.
//
//  Channel | Direction | Handshake        | Payload
//  --------+-----------+------------------+-----------------------------------------------
//  s_*     | in        | s_tvalid/tready  | tdata: in_byte; tuser: start_req
//  m_*     | out       | m_tvalid/tready  | tdata: out_byte, total_length; tlast; tuser: end
//
// Each compressed byte is accepted in ST_IDLE and then handled in ST_PARSE.
// A match copies 2 to 17 bytes: ST_READ reads each copied byte from the history RAM,
// and ST_COPY writes it back and loads the output register.
// Reset leaves the history unwritten; a fill count marks never-written entries as zero,
// so neither reset nor start_req needs a clearing pass.
// A stalled output register holds the sequencer until the result has been taken.
module lzss_stream_decompressor_core #(
    parameter int unsigned HISTORY_DEPTH = lzsd_pkg::HISTORY_DEPTH_DEF,
    parameter int unsigned LENGTH_WIDTH  = lzsd_pkg::LENGTH_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic [0:0]  s_tuser,   // [0] start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_byte, [31:8] total_length
    output logic        m_tlast,   // last_of_run
    output logic [0:0]  m_tuser    // [0] end_of_stream
);

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);
    localparam int unsigned FW = AW + 1;
    localparam logic [FW-1:0] FILL_MAX = FW'(HISTORY_DEPTH);

    // Control state.
    lzsd_pkg::state_t            state_reg, state_next;
    lzsd_pkg::phase_t            phase_reg, phase_next;
    logic [7:0]                  flag_reg, flag_next;
    logic [3:0]                  flags_left_reg, flags_left_next;
    logic [7:0]                  held_reg, held_next;
    logic [AW-1:0]               wp_reg, wp_next;
    logic [FW-1:0]               fill_reg, fill_next;
    logic [LENGTH_WIDTH-1:0]     total_reg, total_next;
    logic                        done_reg, done_next;
    logic [lzsd_pkg::LEFT_W-1:0] left_reg, left_next;
    logic                        hit_reg, hit_next;
    logic                        out_valid_reg, out_valid_next;

    // Payload registers.
    logic [7:0]                  in_byte_reg;
    logic [AW-1:0]               dist_reg, dist_next;
    logic [7:0]                  out_byte_reg, out_byte_next;
    logic                        out_last_reg, out_last_next;
    logic                        out_end_reg, out_end_next;
    logic [lzsd_pkg::TOTAL_W-1:0] out_total_reg, out_total_next;

    // Datapath helpers.
    logic                        in_xfer;
    logic                        out_free;
    logic                        out_load;
    logic [LENGTH_WIDTH-1:0]     total_inc;
    logic [FW-1:0]               fill_inc;
    logic [3:0]                  flags_dec;
    logic                        ram_we;
    logic [7:0]                  ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [7:0]                  ram_rdata;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Saturating byte counter, fill count and flag counter steps.
    assign total_inc = (total_reg == '1) ? total_reg : total_reg + LENGTH_WIDTH'(1);
    assign fill_inc  = (fill_reg == FILL_MAX) ? fill_reg : fill_reg + FW'(1);
    assign flags_dec = flags_left_reg - 4'd1;

    // Copy source sits the match distance behind the write position.
    assign ram_raddr = wp_reg - dist_reg;

    // History ring.
    lzsd_ram #(
        .WIDTH (lzsd_pkg::BYTE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer: next state and datapath control.
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        flag_next       = flag_reg;
        flags_left_next = flags_left_reg;
        held_next       = held_reg;
        wp_next         = wp_reg;
        fill_next       = fill_reg;
        total_next      = total_reg;
        done_next       = done_reg;
        left_next       = left_reg;
        hit_next        = hit_reg;
        dist_next       = dist_reg;
        out_load        = 1'b0;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_end_next    = out_end_reg;
        out_total_next  = out_total_reg;
        ram_we          = 1'b0;
        ram_wdata       = in_byte_reg;
        s_tready        = 1'b0;

        unique case (state_reg)
            lzsd_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (in_xfer)
                begin
                    state_next = lzsd_pkg::ST_PARSE;
                    // A start request wipes the stream state before parsing.
                    if (s_tuser[0])
                    begin
                        phase_next      = lzsd_pkg::PH_TAG;
                        flag_next       = '0;
                        flags_left_next = '0;
                        held_next       = '0;
                        wp_next         = '0;
                        fill_next       = '0;
                        total_next      = '0;
                        done_next       = 1'b0;
                    end
                end
            end

            lzsd_pkg::ST_PARSE:
            begin
                if (done_reg)
                begin
                    // Bytes after the end marker are dropped.
                    state_next = lzsd_pkg::ST_IDLE;
                end
                else
                begin
                    unique case (phase_reg)
                        lzsd_pkg::PH_ITEM:
                        begin
                            if (!flag_reg[7])
                            begin
                                // Literal byte: write to history and emit.
                                if (out_free)
                                begin
                                    ram_we          = 1'b1;
                                    wp_next         = wp_reg + AW'(1);
                                    fill_next       = fill_inc;
                                    total_next      = total_inc;
                                    out_load        = 1'b1;
                                    out_byte_next   = in_byte_reg;
                                    out_last_next   = 1'b1;
                                    out_end_next    = 1'b0;
                                    out_total_next  = lzsd_pkg::TOTAL_W'(total_inc);
                                    flag_next       = {flag_reg[6:0], 1'b0};
                                    flags_left_next = flags_dec;
                                    phase_next      = (flags_dec == 4'd0) ?
                                                      lzsd_pkg::PH_TAG : lzsd_pkg::PH_ITEM;
                                    state_next      = lzsd_pkg::ST_IDLE;
                                end
                            end
                            else if (in_byte_reg == 8'd0)
                            begin
                                // Zero count byte ends the stream.
                                if (out_free)
                                begin
                                    out_load       = 1'b1;
                                    out_byte_next  = '0;
                                    out_last_next  = 1'b1;
                                    out_end_next   = 1'b1;
                                    out_total_next = lzsd_pkg::TOTAL_W'(total_reg);
                                    done_next      = 1'b1;
                                    phase_next     = lzsd_pkg::PH_TAG;
                                    state_next     = lzsd_pkg::ST_IDLE;
                                end
                            end
                            else
                            begin
                                held_next  = in_byte_reg;
                                phase_next = lzsd_pkg::PH_LOW;
                                state_next = lzsd_pkg::ST_IDLE;
                            end
                        end

                        lzsd_pkg::PH_LOW:
                        begin
                            // Offset-low byte completes the match; start the copy.
                            dist_next       = AW'({held_reg[7:4], in_byte_reg});
                            left_next       = lzsd_pkg::LEFT_W'(held_reg[3:0]) +
                                              lzsd_pkg::LEFT_W'(1);
                            flag_next       = {flag_reg[6:0], 1'b0};
                            flags_left_next = flags_dec;
                            phase_next      = (flags_dec == 4'd0) ?
                                              lzsd_pkg::PH_TAG : lzsd_pkg::PH_ITEM;
                            state_next      = lzsd_pkg::ST_READ;
                        end

                        default:
                        begin
                            // Tag byte loads eight fresh flags.
                            flag_next       = in_byte_reg;
                            flags_left_next = lzsd_pkg::FLAGS_PER_TAG;
                            phase_next      = lzsd_pkg::PH_ITEM;
                            state_next      = lzsd_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            lzsd_pkg::ST_READ:
            begin
                // Entries beyond the fill count were never written and read as zero.
                hit_next   = {1'b0, ram_raddr} < fill_reg;
                state_next = lzsd_pkg::ST_COPY;
            end

            lzsd_pkg::ST_COPY:
            begin
                if (out_free)
                begin
                    ram_we         = 1'b1;
                    ram_wdata      = hit_reg ? ram_rdata : 8'd0;
                    wp_next        = wp_reg + AW'(1);
                    fill_next      = fill_inc;
                    total_next     = total_inc;
                    out_load       = 1'b1;
                    out_byte_next  = ram_wdata;
                    out_last_next  = (left_reg == '0);
                    out_end_next   = 1'b0;
                    out_total_next = lzsd_pkg::TOTAL_W'(total_inc);
                    if (left_reg == '0)
                    begin
                        state_next = lzsd_pkg::ST_IDLE;
                    end
                    else
                    begin
                        left_next  = left_reg - lzsd_pkg::LEFT_W'(1);
                        state_next = lzsd_pkg::ST_READ;
                    end
                end
            end

            default:
            begin
                state_next = lzsd_pkg::ST_IDLE;
            end
        endcase

        // Output register is filled by the sequencer and drained by the sink.
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lzsd_pkg::ST_IDLE;
            phase_reg      <= lzsd_pkg::PH_TAG;
            flag_reg       <= '0;
            flags_left_reg <= '0;
            held_reg       <= '0;
            wp_reg         <= '0;
            fill_reg       <= '0;
            total_reg      <= '0;
            done_reg       <= 1'b0;
            left_reg       <= '0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            flag_reg       <= flag_next;
            flags_left_reg <= flags_left_next;
            held_reg       <= held_next;
            wp_reg         <= wp_next;
            fill_reg       <= fill_next;
            total_reg      <= total_next;
            done_reg       <= done_next;
            left_reg       <= left_next;
            hit_reg        <= hit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_byte_reg <= s_tdata;
        end
        dist_reg      <= dist_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_end_reg   <= out_end_next;
        out_total_reg <= out_total_next;
    end

    // Output channel.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_total_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_end_reg;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the LZSS stream decompressor core.
`timescale 1ns / 100ps

module tb;
    import lzsd_pkg::*;

    // One compressed byte waiting to be driven.
    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              start;
        logic              hold;
    } packed_byte_t;

    // One decompressed result as the block should present it.
    typedef struct {
        logic [BYTE_W-1:0]  data;
        logic               last;
        logic               eos;
        logic [TOTAL_W-1:0] total;
    } plain_byte_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;    // [7:0] in_byte
    logic [0:0]  s_tuser  = '0;    // [0] start_req
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [7:0] out_byte, [31:8] total_length
    logic        m_tlast;
    logic [0:0]  m_tuser;          // [0] end_of_stream

    lzss_stream_decompressor_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    packed_byte_t compressed_q[$];
    plain_byte_t  plain_exp_q[$];

    int tx_idle         = 26;
    int rx_idle         = 80;
    int results_waiting = 0;
    int err_count       = 0;

    // Generator bookkeeping.
    int item_count = 0;
    bit hold_next  = 1'b0;
    bit gen_ended  = 1'b0;

    // Decoder copy: history window, parse position and running total.
    logic [BYTE_W-1:0]  window [HISTORY_DEPTH_DEF];
    phase_t             ph;
    logic [7:0]         flags;
    logic [3:0]         flags_rem;
    logic [7:0]         count_byte;
    logic [11:0]        wr_pos;
    logic [TOTAL_W-1:0] out_total;
    logic               done;

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("%s", msg);
    endtask

    // A new stream forgets the window, the parse position and the total.
    task automatic restart_stream();
        for (int i = 0; i < HISTORY_DEPTH_DEF; i++)
            window[i] = '0;
        ph         = PH_TAG;
        flags      = '0;
        flags_rem  = '0;
        count_byte = '0;
        wr_pos     = '0;
        out_total  = '0;
        done       = 1'b0;
    endtask

    // Write one byte into the window and expect it on the output.
    task automatic put_plain(input logic [7:0] b, input logic last);
        plain_byte_t r;
        window[wr_pos] = b;
        wr_pos = wr_pos + 1'b1;
        if (out_total != '1)
            out_total = out_total + 1'b1;
        r.data  = b;
        r.last  = last;
        r.eos   = 1'b0;
        r.total = out_total;
        plain_exp_q.push_back(r);
    endtask

    task automatic advance_flag();
        flags     = flags << 1;
        flags_rem = flags_rem - 1'b1;
        if (flags_rem == 0)
            ph = PH_TAG;
        else
            ph = PH_ITEM;
    endtask

    // Work out the results that one accepted compressed byte causes.
    task automatic decode_byte(input logic [7:0] b, input logic start);
        plain_byte_t r;
        logic [11:0] back_offset;
        logic [11:0] rd;
        int          len;
        if (start)
            restart_stream();
        if (!done)
        begin
            case (ph)
                PH_ITEM:
                begin
                    if (!flags[7])
                    begin
                        put_plain(b, 1'b1);
                        advance_flag();
                    end
                    else if (b == 8'h00)
                    begin
                        // A zero count byte closes the stream.
                        r.data  = '0;
                        r.last  = 1'b1;
                        r.eos   = 1'b1;
                        r.total = out_total;
                        plain_exp_q.push_back(r);
                        done = 1'b1;
                        ph   = PH_TAG;
                    end
                    else
                    begin
                        count_byte = b;
                        ph         = PH_LOW;
                    end
                end
                PH_LOW:
                begin
                    // Copies read one byte at a time, so overlaps repeat data.
                    back_offset = {count_byte[7:4], b};
                    len  = int'(count_byte[3:0]) + 2;
                    for (int i = 0; i < len; i++)
                    begin
                        rd = wr_pos - back_offset;
                        put_plain(window[rd], i == len - 1);
                    end
                    advance_flag();
                end
                default:
                begin
                    flags     = b;
                    flags_rem = FLAGS_PER_TAG;
                    ph        = PH_ITEM;
                end
            endcase
        end
    endtask

    task automatic add_byte(input logic [7:0] data, input logic start);
        packed_byte_t it;
        it.data   = data;
        it.start  = start;
        it.hold   = hold_next;
        hold_next = 1'b0;
        if (start)
            gen_ended = 1'b0;
        item_count++;
        compressed_q.push_back(it);
    endtask

    // Build a stream of literals and matches, closed by an end marker if asked.
    task automatic send_stream(input int tokens, input bit with_start, input bit terminate);
        int         slots;
        int         n;
        logic [7:0] tag;
        logic [3:0] hi;
        logic [7:0] cnt;
        logic [7:0] lo;
        bit         first;
        slots = tokens + int'(terminate);
        first = with_start || gen_ended;
        while (slots > 0)
        begin
            n   = (slots > 8) ? 8 : slots;
            tag = 8'($urandom_range(0, 255));
            if (terminate && slots <= 8)
                tag[8 - n] = 1'b1;
            add_byte(tag, first);
            first = 1'b0;
            for (int j = 0; j < n; j++)
            begin
                if (terminate && slots == n && j == n - 1)
                begin
                    add_byte(8'h00, 1'b0);
                    gen_ended = 1'b1;
                end
                else if (!tag[7 - j])
                    add_byte(8'($urandom_range(0, 255)), 1'b0);
                else
                begin
                    // Mostly short distances so that copies read fresh data.
                    hi  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'd0;
                    cnt = {hi, 4'($urandom_range(0, 15))};
                    if (cnt == 8'h00)
                        cnt = 8'h01;
                    lo = 8'($urandom_range(0, 255));
                    if (hi == 4'd0 && $urandom_range(0, 1) == 1)
                        lo = 8'($urandom_range(1, 16));
                    add_byte(cnt, 1'b0);
                    add_byte(lo, 1'b0);
                end
            end
            slots -= n;
        end
    endtask

    // Mostly well-formed streams, with some noise and some cut-off streams.
    task automatic random_chunk();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            repeat ($urandom_range(1, 6))
                add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
        else if (r == 1)
            send_stream($urandom_range(1, 10), 1'($urandom_range(0, 1)), 1'b0);
        else
        begin
            send_stream($urandom_range(1, 24), $urandom_range(0, 7) != 0, 1'b1);
            repeat ($urandom_range(0, 2))
                add_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // Driver: one compressed byte per transfer, with random gaps.
    always @(posedge clk)
    begin : drive_blk
        packed_byte_t it;
        if (rst_n)
        begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle);
            if (!s_tvalid || s_tready)
            begin
                if (compressed_q.size() == 0 || $urandom_range(0, 99) < tx_idle)
                    s_tvalid <= 1'b0;
                else if (compressed_q[0].hold && (s_tvalid || results_waiting != 0))
                    s_tvalid <= 1'b0;
                else
                begin
                    it = compressed_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= it.data;
                    s_tuser  <= it.start;
                end
            end
        end
    end

    // Monitor: predict from input transfers, check output transfers.
    always @(posedge clk)
    begin : check_blk
        plain_byte_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tuser[0]);
            if (m_tvalid && m_tready)
            begin
                if (plain_exp_q.size() == 0)
                    flag_error($sformatf("unexpected result: byte %02h last %0b end %0b",
                                         m_tdata[7:0], m_tlast, m_tuser[0]));
                else
                begin
                    want = plain_exp_q.pop_front();
                    if (m_tdata[7:0] !== want.data || m_tlast !== want.last ||
                        m_tuser[0] !== want.eos || m_tdata[31:8] !== want.total)
                        flag_error($sformatf({"mismatch: expected byte %02h last %0b ",
                                              "end %0b total %0d, got byte %02h last %0b ",
                                              "end %0b total %0d"},
                                             want.data, want.last, want.eos, want.total,
                                             m_tdata[7:0], m_tlast, m_tuser[0],
                                             m_tdata[31:8]));
                end
            end
            results_waiting <= plain_exp_q.size();
        end
    end

    // Stimulus sequence and end of run.
    initial
    begin : stimulus
        int target [3];
        target = '{160, 310, 460};
        restart_stream();

        // Directed stream without a start flag, straight after reset.
        add_byte(8'h5A, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h0F, 1'b0);        // longest match, distance one: overlapping copy
        add_byte(8'h01, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h01, 1'b0);        // distance zero reads the oldest window entry
        add_byte(8'h00, 1'b0);
        add_byte(8'hF0, 1'b0);        // largest distance
        add_byte(8'hFF, 1'b0);
        add_byte(8'hA5, 1'b0);
        add_byte(8'h10, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h5A, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h00, 1'b0);        // end marker
        gen_ended = 1'b1;
        add_byte(8'hFF, 1'b0);        // ignored after the end
        add_byte(8'h00, 1'b0);
        // Empty stream: the end marker comes first.
        add_byte(8'hFF, 1'b1);
        add_byte(8'h00, 1'b0);
        gen_ended = 1'b1;
        add_byte(8'h00, 1'b1);
        add_byte(8'h80, 1'b0);
        add_byte(8'h7F, 1'b0);

        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < 3; p++)
        begin
            tx_idle   = (p == 0) ? 26 : (p == 1) ? 80 : 0;
            rx_idle   = (p == 0) ? 80 : (p == 1) ? 26 : 0;
            hold_next = 1'b1;
            while (item_count < target[p])
                random_chunk();
            while (compressed_q.size() != 0)
                @(negedge clk);
        end

        while (s_tvalid || plain_exp_q.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (plain_exp_q.size() != 0)
            flag_error($sformatf("%0d results never arrived", plain_exp_q.size()));

        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
